@@ src/circular_queue_with_peek_macros.svh @@
// Assertion macros for the circular queue checker.
`ifndef CIRCULAR_QUEUE_WITH_PEEK_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_PEEK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CQP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CQP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cqp_pkg.sv @@
// Types, codes and helpers shared by the circular queue modules.
`default_nettype none
package cqp_pkg;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam count_t CAP_RESET = count_t'(256);

  localparam logic [1:0] OP_ENQ        = 2'd0;
  localparam logic [1:0] OP_DEQ        = 2'd1;
  localparam logic [1:0] OP_PEEK_FRONT = 2'd2;
  localparam logic [1:0] OP_PEEK_REAR  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    count_t             item_count;
    logic               is_full;
    logic               is_empty;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  status;
    count_t      item_count;
    logic        is_full;
    logic        is_empty;
  } meta_t;

  typedef struct packed {
    logic [1:0]  kind;
    addr_t       addr;
    logic [31:0] wdata;
    meta_t       meta;
  } cmd_t;

  function automatic addr_t bump(input addr_t idx, input count_t cap);
    logic [31:0] n;
    n = 32'(idx) + 32'd1;
    return (n >= 32'(cap)) ? '0 : addr_t'(n);
  endfunction

  function automatic count_t eff_cap(input count_t cap);
    count_t c;
    c = cap;
    if (c == '0) begin
      c = count_t'(1);
    end
    if (32'(c) > STORE_DEPTH) begin
      c = count_t'(STORE_DEPTH);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/cqp_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module cqp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

@@ src/cqp_front.sv @@
// Front end: accepts transactions, tracks pointers and count, issues commands.
`default_nettype none
module cqp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire cqp_pkg::in_item_t item,
  input  wire logic              cfg_write,
  input  wire cqp_pkg::count_t   cfg_data,
  output logic                   cmd_valid,
  input  wire logic              cmd_stall,
  output cqp_pkg::cmd_t          cmd
);
  import cqp_pkg::*;

  addr_t  head, head_next;
  addr_t  tail, tail_next;
  count_t count, count_next;
  count_t capacity;
  count_t cap;
  logic   accept;

  assign cap        = eff_cap(capacity);
  assign item_stall = cmd_stall;
  assign cmd_valid  = item_valid;
  assign accept     = item_valid && !cmd_stall;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    cmd.kind   = CMD_NONE;
    cmd.addr   = head;
    cmd.wdata  = item.item_value;
    cmd.meta.status = ST_DONE;
    if (item.operation == OP_ENQ) begin
      if (count >= cap) begin
        cmd.meta.status = ST_FULL;
      end else begin
        if (count == '0) begin
          head_next = '0;
          tail_next = '0;
        end else begin
          tail_next = bump(tail, cap);
        end
        cmd.kind   = CMD_WRITE;
        cmd.addr   = tail_next;
        count_next = count + count_t'(1);
      end
    end else if (count == '0) begin
      cmd.meta.status = ST_EMPTY;
    end else begin
      cmd.kind = CMD_READ;
      unique case (item.operation)
        OP_DEQ: begin
          count_next = count - count_t'(1);
          if (count != count_t'(1)) begin
            head_next = bump(head, cap);
          end
        end
        OP_PEEK_FRONT: cmd.addr = head;
        OP_PEEK_REAR:  cmd.addr = tail;
        default:       cmd.addr = head;
      endcase
    end
    cmd.meta.item_count = count_next;
    cmd.meta.is_full    = (count_next == cap);
    cmd.meta.is_empty   = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      capacity <= CAP_RESET;
    end else begin
      if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
      if (cfg_write && count == '0) begin
        capacity <= cfg_data;
      end
    end
  end
endmodule
`default_nettype wire

@@ src/cqp_cmd_queue.sv @@
// Short command queue between front and back end.
`default_nettype none
module cqp_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_stall,
  input  wire cqp_pkg::cmd_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output cqp_pkg::cmd_t      pop_data
);
  import cqp_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   fill;
  logic              push, pop;

  assign push_stall = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/cqp_back.sv @@
// Back end: performs store accesses and holds the result register.
`default_nettype none
module cqp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire cqp_pkg::cmd_t     cmd,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output cqp_pkg::out_item_t     result
);
  import cqp_pkg::*;

  logic        pop;
  logic        rd_flag;
  meta_t       meta;
  logic [31:0] rdata;

  assign cmd_ready = !result_valid || !result_stall;
  assign pop       = cmd_valid && cmd_ready;

  cqp_ram #(
    .WIDTH (32),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (pop && cmd.kind == CMD_WRITE),
    .re    (pop && cmd.kind == CMD_READ),
    .addr  (cmd.addr),
    .wdata (cmd.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      meta    <= cmd.meta;
      rd_flag <= (cmd.kind == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd_ready) begin
      result_valid <= cmd_valid;
    end
  end

  assign result.read_value = rd_flag ? rdata : '0;
  assign result.status     = meta.status;
  assign result.item_count = meta.item_count;
  assign result.is_full    = meta.is_full;
  assign result.is_empty   = meta.is_empty;
endmodule
`default_nettype wire

@@ src/circular_queue_with_peek.sv @@
// Top level of the circular queue with peek.
// Circular FIFO of signed 32-bit items with enqueue, dequeue, peek-front and
// peek-rear transactions; every transaction returns one result with status,
// count and full/empty flags. Sustained rate is one transaction per cycle
// while result_stall is low; each result passes through the command queue
// stage, then the registered read of the single-port ring store.
// The input stalls only when the two-entry command queue is full. The store
// has no reset or clearing pass. capacity writes are honored only while the
// queue holds no items; 0 acts as 1 and values above the store depth clamp.
`default_nettype none
module circular_queue_with_peek (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire cqp_pkg::in_item_t  item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output cqp_pkg::out_item_t      result,
  input  wire logic               cfg_write,
  input  wire cqp_pkg::count_t    cfg_data
);
  import cqp_pkg::*;

  logic f_valid, f_stall;
  cmd_t f_cmd;
  logic b_valid, b_ready;
  cmd_t b_cmd;

  cqp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .cmd_valid  (f_valid),
    .cmd_stall  (f_stall),
    .cmd        (f_cmd)
  );

  cqp_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_cmd)
  );

  cqp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (b_valid),
    .cmd_ready    (b_ready),
    .cmd          (b_cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );
endmodule
`default_nettype wire

@@ src/cqp_checker.sv @@
// Port-level assertions for the circular queue, bound to the top level.
`default_nettype none
`include "circular_queue_with_peek_macros.svh"
module cqp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire cqp_pkg::out_item_t result
);
  import cqp_pkg::*;

  `CQP_ASSERT_NEXT(a_hold_valid, result_valid && result_stall, result_valid, "result dropped while stalled")
  `CQP_ASSERT_NOW(a_full_flag, result_valid && result.status == ST_FULL, result.is_full, "full reject without full flag")
  `CQP_ASSERT_NOW(a_empty_rej, result_valid && result.status == ST_EMPTY, result.is_empty && result.read_value == 0, "empty reject with data or count")
  `CQP_ASSERT_NOW(a_flags, result_valid, !(result.is_full && result.is_empty), "full and empty together")
endmodule

bind circular_queue_with_peek cqp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire

@@ test/circular_queue_with_peek_tb.sv @@
// Testbench for circular_queue_with_peek: directed and random transactions checked against a queue predictor.
module circular_queue_with_peek_tb;
  import cqp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;
  logic      cfg_write = 1'b0;
  count_t    cfg_data = '0;

  circular_queue_with_peek dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  logic signed [31:0] model_store [STORE_DEPTH];
  int                 model_head = 0;
  int                 model_tail = 0;
  int                 model_count = 0;
  count_t             model_cap = CAP_RESET;

  out_item_t expected_results [$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        steady_flow = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("circular_queue_with_peek verification failed");
      $finish;
    end
  end

  function automatic int model_capacity();
    int c;
    c = int'(model_cap);
    if (c == 0) c = 1;
    if (c > STORE_DEPTH) c = STORE_DEPTH;
    return c;
  endfunction

  function automatic out_item_t apply_queue_op(input logic [1:0] op,
                                               input logic signed [31:0] value);
    out_item_t r;
    int        cap;
    cap = model_capacity();
    r = '0;
    r.status = ST_DONE;
    if (op == OP_ENQ) begin
      if (model_count >= cap) begin
        r.status = ST_FULL;
      end else begin
        if (model_count == 0) begin
          model_head = 0;
          model_tail = 0;
        end else begin
          model_tail = (model_tail + 1 >= cap) ? 0 : model_tail + 1;
        end
        model_store[model_tail] = value;
        model_count++;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_DEQ) begin
      r.read_value = model_store[model_head];
      model_count--;
      if (model_count != 0) model_head = (model_head + 1 >= cap) ? 0 : model_head + 1;
    end else if (op == OP_PEEK_FRONT) begin
      r.read_value = model_store[model_head];
    end else begin
      r.read_value = model_store[model_tail];
    end
    r.item_count = count_t'(model_count);
    r.is_full    = (model_count == cap);
    r.is_empty   = (model_count == 0);
    return r;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  always @(negedge clk) begin
    result_stall <= steady_flow ? 1'b0 : ($urandom_range(0, 99) < 24);
  end

  always @(posedge clk) begin : result_check
    out_item_t exp;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("cycle %0d: result with no pending transaction", cycle_count));
      end else begin
        exp = expected_results.pop_front();
        if (result.read_value !== exp.read_value || result.status !== exp.status ||
            result.item_count !== exp.item_count || result.is_full !== exp.is_full ||
            result.is_empty !== exp.is_empty) begin
          note_error($sformatf(
            "cycle %0d: expected value=%0d status=%0d count=%0d full=%0b empty=%0b, got value=%0d status=%0d count=%0d full=%0b empty=%0b",
            cycle_count, exp.read_value, exp.status, exp.item_count, exp.is_full,
            exp.is_empty, result.read_value, result.status, result.item_count,
            result.is_full, result.is_empty));
        end
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic signed [31:0] value);
    in_item_t txn;
    txn.operation  = op;
    txn.item_value = value;
    @(negedge clk);
    while (!steady_flow && $urandom_range(0, 99) < 24) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= txn;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_results.push_back(apply_queue_op(op, value));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input count_t value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    if (model_count == 0) model_cap = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_op(input int enq_pct);
    int r;
    if ($urandom_range(0, 99) < enq_pct) return OP_ENQ;
    r = $urandom_range(0, 9);
    if (r < 6) return OP_DEQ;
    if (r < 8) return OP_PEEK_FRONT;
    return OP_PEEK_REAR;
  endfunction

  task automatic empty_queue();
    while (model_count > 0) send_op(OP_DEQ, random_value());
  endtask

  task automatic test_empty_rejects();
    send_op(OP_DEQ, 32'sh7fff_ffff);
    send_op(OP_PEEK_FRONT, 32'sh8000_0000);
    send_op(OP_PEEK_REAR, -32'sd1);
  endtask

  task automatic test_value_extremes();
    send_op(OP_ENQ, 32'sh8000_0000);
    send_op(OP_ENQ, 32'sh7fff_ffff);
    send_op(OP_ENQ, '0);
    send_op(OP_ENQ, -32'sd1);
    send_op(OP_PEEK_FRONT, '0);
    send_op(OP_PEEK_REAR, '0);
    empty_queue();
    send_op(OP_DEQ, '0);
  endtask

  task automatic test_capacity_edges();
    // zero acts as one
    write_capacity('0);
    send_op(OP_ENQ, 32'sh5555_5555);
    send_op(OP_ENQ, 32'sh2aaa_aaaa);
    send_op(OP_PEEK_REAR, '0);
    send_op(OP_DEQ, '0);
    write_capacity(count_t'(2));
    send_op(OP_ENQ, 32'sd11);
    send_op(OP_ENQ, 32'sd22);
    send_op(OP_ENQ, 32'sd33);
    send_op(OP_DEQ, '0);
    send_op(OP_ENQ, 32'sd44);
    send_op(OP_PEEK_FRONT, '0);
    send_op(OP_PEEK_REAR, '0);
    // write while holding items is dropped
    write_capacity(count_t'(9));
    send_op(OP_ENQ, 32'sd55);
    empty_queue();
  endtask

  task automatic test_back_to_back();
    write_capacity(count_t'(4));
    steady_flow = 1'b1;
    repeat (80) send_op(pick_op(50), random_value());
    wait_idle();
    steady_flow = 1'b0;
    empty_queue();
  endtask

  task automatic test_random_phases();
    count_t caps [7];
    caps[0] = count_t'(1);
    caps[1] = count_t'(2);
    caps[2] = count_t'(3);
    caps[3] = count_t'(5);
    caps[4] = '0;
    caps[5] = count_t'(17);
    caps[6] = count_t'($urandom_range(6, 40));
    for (int k = 0; k < 7; k++) begin
      empty_queue();
      write_capacity(caps[k]);
      for (int i = 0; i < 50; i++) send_op(pick_op(i < 25 ? 65 : 35), random_value());
    end
    empty_queue();
  endtask

  task automatic test_fill_to_capacity();
    for (int k = 0; k < 2; k++) begin
      empty_queue();
      write_capacity(k == 0 ? CAP_RESET : count_t'(511));
      while (model_count < model_capacity()) send_op(pick_op(90), random_value());
      repeat (3) send_op(OP_ENQ, random_value());
      repeat (40) send_op(pick_op(50), random_value());
      empty_queue();
      send_op(OP_PEEK_REAR, random_value());
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_empty_rejects();
    test_value_extremes();
    test_capacity_edges();
    test_back_to_back();
    test_random_phases();
    test_fill_to_capacity();
    wait_idle();
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("circular_queue_with_peek verification clean");
    end else begin
      $display("circular_queue_with_peek verification failed");
    end
    $finish;
  end

endmodule

@@ circular_queue_with_peek.f @@
+incdir+src
src/cqp_pkg.sv
src/cqp_ram.sv
src/cqp_front.sv
src/cqp_cmd_queue.sv
src/cqp_back.sv
src/circular_queue_with_peek.sv
src/cqp_checker.sv
test/circular_queue_with_peek_tb.sv
